>>> sv/wah_pkg.sv
// ----------------------------------------------------------------------------
// wah_pkg
// Shared types and constants of the resonant two-pole filter.
// ----------------------------------------------------------------------------
package wah_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int ACC_WIDTH_DEF    = 40;

  localparam logic [31:0] FREQ_SCALE_RST = 32'd27827;

  // shared multiplier operand and product widths
  localparam int MW = 33;
  localparam int PW = 2 * MW;

  // divider: dividend is theta << 8
  localparam int DIV_W  = 40;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L_FS,
    S_L_THETA,
    S_L_TT,
    S_L_COS,
    S_DIV,
    S_L_R,
    S_L_RC,
    S_L_RR,
    S_L_RS,
    S_L_T,
    S_L_OT,
    S_L_G,
    S_F_B1H,
    S_F_B1L,
    S_F_B2H,
    S_F_B2L,
    S_F_Y,
    S_F_GH,
    S_F_GL,
    S_F_OUT
  } state_t;

  typedef enum logic [3:0] {
    MUL_FS,
    MUL_TT,
    MUL_RC,
    MUL_RR,
    MUL_RS,
    MUL_OT,
    MUL_B1H,
    MUL_B1L,
    MUL_B2H,
    MUL_B2L,
    MUL_GH,
    MUL_GL
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     hi_en;
    logic     theta_en;
    logic     cos_en;
    logic     div_start;
    logic     div_step;
    logic     r_en;
    logic     b1_en;
    logic     b2_en;
    logic     t_en;
    logic     gain_en;
    logic     acc_init;
    logic     acc_sub;
    logic     y_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

>>> sv/wah_dp.sv
// ----------------------------------------------------------------------------
// wah_dp
// Datapath: shared multiplier, radix-2 divider, coefficient and filter state,
// output register.
// ----------------------------------------------------------------------------
module wah_dp #(
  parameter int SAMPLE_WIDTH = wah_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = wah_pkg::ACC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [31:0]                    cfg_wdata,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic [15:0]                    in_center_freq,
  input  logic [15:0]                    in_quality,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  wah_pkg::cmd_t                  cmd,
  output wah_pkg::status_t               status
);

  localparam int MW       = wah_pkg::MW;
  localparam int PW       = wah_pkg::PW;
  localparam int AW       = ACC_WIDTH + 4;
  localparam int OW       = ACC_WIDTH + 16;
  localparam int ACC_FRAC = ACC_WIDTH - 9;
  localparam int SMP_FRAC = SAMPLE_WIDTH - 1;
  localparam int DSH      = (ACC_FRAC >= SMP_FRAC) ? (ACC_FRAC - SMP_FRAC)
                                                   : (SMP_FRAC - ACC_FRAC);

  localparam logic signed [PW-1:0] THETA_LIM = {{(PW-34){1'b0}}, 1'b1, 33'b0};
  localparam logic signed [PW-1:0] ONE_PW    = {{(PW-31){1'b0}}, wah_pkg::ONE_Q30};
  localparam logic signed [AW-1:0] ACC_MAX   = {{(AW-ACC_WIDTH+1){1'b0}},
                                                {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN   = ~ACC_MAX;
  localparam logic signed [OW-1:0] SMP_MAX   = {{(OW-SAMPLE_WIDTH+1){1'b0}},
                                                {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [OW-1:0] SMP_MIN   = ~SMP_MAX;

  logic [31:0]                    scale_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic [15:0]                    f_r;
  logic [15:0]                    q_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [PW-1:0]           hi_r;
  logic [31:0]                    theta_r;
  logic signed [31:0]             cos_r;
  logic [wah_pkg::DIV_W-1:0]      dq_r;
  logic [16:0]                    rem_r;
  logic [wah_pkg::CNT_W-1:0]      cnt_r;
  logic [30:0]                    r_r;
  logic [31:0]                    t_r;
  logic signed [31:0]             b1_r;
  logic signed [31:0]             b2_r;
  logic signed [31:0]             gain_r;
  logic signed [ACC_WIDTH-1:0]    y1_r;
  logic signed [ACC_WIDTH-1:0]    y2_r;
  logic signed [AW-1:0]           acc_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;
  logic                           out_valid_r;

  logic signed [MW-1:0] op_a;
  logic signed [MW-1:0] op_b;
  logic signed [PW-1:0] prod_nxt;
  logic [30:0]          sin_v;
  logic [30:0]          omr;
  logic signed [PW-1:0] sh30;
  logic signed [PW-1:0] sh31;
  logic signed [PW-1:0] neg30;
  logic signed [PW-1:0] cos_full;
  logic signed [PW-1:0] tsum;
  logic signed [PW-1:0] tfull;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] diff;
  logic signed [AW-1:0] xa;
  logic signed [ACC_WIDTH-1:0] ysat;
  logic signed [AW-1:0] osat;
  logic signed [OW-1:0] ow;
  logic signed [SAMPLE_WIDTH-1:0] out_nxt;
  logic [17:0]          rem_sh;
  logic [17:0]          rem_df;
  logic [30:0]          r_nxt;

  function automatic logic signed [MW-1:0] yh(input logic signed [ACC_WIDTH-1:0] y);
    yh = {{(MW-ACC_WIDTH+16){y[ACC_WIDTH-1]}}, y[ACC_WIDTH-1:16]};
  endfunction

  function automatic logic signed [MW-1:0] yl(input logic signed [ACC_WIDTH-1:0] y);
    yl = {{(MW-16){1'b0}}, y[15:0]};
  endfunction

  always_comb begin
    sin_v = (theta_r > {1'b0, wah_pkg::ONE_Q30}) ? wah_pkg::ONE_Q30 : theta_r[30:0];
    omr   = wah_pkg::ONE_Q30 - r_r;
    op_a  = '0;
    op_b  = '0;
    case (cmd.mul_sel)
      wah_pkg::MUL_FS: begin
        op_a = {{(MW-16){1'b0}}, f_r};
        op_b = {1'b0, scale_r};
      end
      wah_pkg::MUL_TT: begin
        op_a = {1'b0, theta_r};
        op_b = {1'b0, theta_r};
      end
      wah_pkg::MUL_RC: begin
        op_a = {2'b0, r_r};
        op_b = {cos_r[31], cos_r};
      end
      wah_pkg::MUL_RR: begin
        op_a = {2'b0, r_r};
        op_b = {2'b0, r_r};
      end
      wah_pkg::MUL_RS: begin
        op_a = {2'b0, r_r};
        op_b = {2'b0, sin_v};
      end
      wah_pkg::MUL_OT: begin
        op_a = {2'b0, omr};
        op_b = {1'b0, t_r};
      end
      wah_pkg::MUL_B1H: begin
        op_a = {b1_r[31], b1_r};
        op_b = yh(y1_r);
      end
      wah_pkg::MUL_B1L: begin
        op_a = {b1_r[31], b1_r};
        op_b = yl(y1_r);
      end
      wah_pkg::MUL_B2H: begin
        op_a = {b2_r[31], b2_r};
        op_b = yh(y2_r);
      end
      wah_pkg::MUL_B2L: begin
        op_a = {b2_r[31], b2_r};
        op_b = yl(y2_r);
      end
      wah_pkg::MUL_GH: begin
        op_a = {gain_r[31], gain_r};
        op_b = yh(y1_r);
      end
      wah_pkg::MUL_GL: begin
        op_a = {gain_r[31], gain_r};
        op_b = yl(y1_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_nxt = op_a * op_b;

    sh30     = prod_r >>> 30;
    sh31     = prod_r >>> 31;
    neg30    = -sh30;
    cos_full = ONE_PW - sh31;

    // floor(b * y / 2^29) from its high and low partial products
    tsum  = hi_r + (prod_r >>> 16);
    tfull = tsum >>> 13;
    term  = tfull[AW-1:0];
    diff  = acc_r - term;

    if (ACC_FRAC >= SMP_FRAC) begin
      xa = $signed({{(AW-SAMPLE_WIDTH){x_r[SAMPLE_WIDTH-1]}}, x_r}) <<< DSH;
    end else begin
      xa = $signed({{(AW-SAMPLE_WIDTH){x_r[SAMPLE_WIDTH-1]}}, x_r}) >>> DSH;
    end

    if (diff > ACC_MAX) begin
      ysat = ACC_MAX[ACC_WIDTH-1:0];
    end else if (diff < ACC_MIN) begin
      ysat = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      ysat = diff[ACC_WIDTH-1:0];
    end

    if (term > ACC_MAX) begin
      osat = ACC_MAX;
    end else if (term < ACC_MIN) begin
      osat = ACC_MIN;
    end else begin
      osat = term;
    end

    if (ACC_FRAC >= SMP_FRAC) begin
      ow = $signed({{(OW-AW){term[AW-1]}}, term}) >>> DSH;
    end else begin
      ow = $signed({{(OW-AW){osat[AW-1]}}, osat}) <<< DSH;
    end

    if (ow > SMP_MAX) begin
      out_nxt = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (ow < SMP_MIN) begin
      out_nxt = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      out_nxt = ow[SAMPLE_WIDTH-1:0];
    end

    rem_sh = {rem_r, dq_r[wah_pkg::DIV_W-1]};
    rem_df = rem_sh - {2'b0, q_r};

    r_nxt = (dq_r[wah_pkg::DIV_W-1:30] != '0) ? '0 : wah_pkg::ONE_Q30 - dq_r[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= wah_pkg::FREQ_SCALE_RST;
      b1_r        <= '0;
      b2_r        <= '0;
      gain_r      <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
      if (cmd.b1_en) begin
        b1_r <= neg30[31:0];
      end
      if (cmd.b2_en) begin
        b2_r <= sh31[31:0];
      end
      if (cmd.gain_en) begin
        gain_r <= sh31[31:0];
      end
      if (cmd.y_en) begin
        y2_r <= y1_r;
        y1_r <= ysat;
      end
      if (cmd.div_start) begin
        cnt_r <= wah_pkg::CNT_W'(wah_pkg::DIV_W);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      x_r <= in_sample_in;
      f_r <= in_center_freq;
      q_r <= in_quality;
    end
    if (cmd.hi_en) begin
      hi_r <= prod_r;
    end
    if (cmd.theta_en) begin
      theta_r <= (prod_r > THETA_LIM) ? 32'h8000_0000 : prod_r[33:2];
    end
    if (cmd.cos_en) begin
      cos_r <= cos_full[31:0];
    end
    if (cmd.div_start) begin
      dq_r  <= {theta_r, 8'b0};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!rem_df[17]) begin
        rem_r <= rem_df[16:0];
        dq_r  <= {dq_r[wah_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[16:0];
        dq_r  <= {dq_r[wah_pkg::DIV_W-2:0], 1'b0};
      end
    end
    if (cmd.r_en) begin
      r_r <= r_nxt;
    end
    if (cmd.t_en) begin
      t_r <= {1'b0, omr} + sh30[31:0];
    end
    if (cmd.acc_init) begin
      acc_r <= xa;
    end else if (cmd.acc_sub) begin
      acc_r <= diff;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign status.div_done = (cnt_r == wah_pkg::CNT_W'(1));
  assign status.out_busy = out_valid_r & out_stall;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_r;

endmodule

>>> sv/wah_ctrl.sv
// ----------------------------------------------------------------------------
// wah_ctrl
// Controller: sequences coefficient update and per-sample filter steps.
// ----------------------------------------------------------------------------
module wah_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_block_start,
  output logic             in_stall,
  output wah_pkg::cmd_t    cmd,
  input  wah_pkg::status_t status
);

  wah_pkg::state_t state_r;
  wah_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wah_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = wah_pkg::MUL_FS;
    in_stall    = (state_r != wah_pkg::S_IDLE);
    case (state_r)
      wah_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_block_start ? wah_pkg::S_L_FS : wah_pkg::S_F_B1H;
        end
      end
      wah_pkg::S_L_FS: begin
        cmd.mul_sel = wah_pkg::MUL_FS;
        state_nxt   = wah_pkg::S_L_THETA;
      end
      wah_pkg::S_L_THETA: begin
        cmd.theta_en = 1'b1;
        state_nxt    = wah_pkg::S_L_TT;
      end
      wah_pkg::S_L_TT: begin
        cmd.mul_sel = wah_pkg::MUL_TT;
        state_nxt   = wah_pkg::S_L_COS;
      end
      wah_pkg::S_L_COS: begin
        cmd.cos_en    = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = wah_pkg::S_DIV;
      end
      wah_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = wah_pkg::S_L_R;
        end
      end
      wah_pkg::S_L_R: begin
        cmd.r_en  = 1'b1;
        state_nxt = wah_pkg::S_L_RC;
      end
      wah_pkg::S_L_RC: begin
        cmd.mul_sel = wah_pkg::MUL_RC;
        state_nxt   = wah_pkg::S_L_RR;
      end
      wah_pkg::S_L_RR: begin
        cmd.b1_en   = 1'b1;
        cmd.mul_sel = wah_pkg::MUL_RR;
        state_nxt   = wah_pkg::S_L_RS;
      end
      wah_pkg::S_L_RS: begin
        cmd.b2_en   = 1'b1;
        cmd.mul_sel = wah_pkg::MUL_RS;
        state_nxt   = wah_pkg::S_L_T;
      end
      wah_pkg::S_L_T: begin
        cmd.t_en  = 1'b1;
        state_nxt = wah_pkg::S_L_OT;
      end
      wah_pkg::S_L_OT: begin
        cmd.mul_sel = wah_pkg::MUL_OT;
        state_nxt   = wah_pkg::S_L_G;
      end
      wah_pkg::S_L_G: begin
        cmd.gain_en = 1'b1;
        state_nxt   = wah_pkg::S_F_B1H;
      end
      wah_pkg::S_F_B1H: begin
        cmd.acc_init = 1'b1;
        cmd.mul_sel  = wah_pkg::MUL_B1H;
        state_nxt    = wah_pkg::S_F_B1L;
      end
      wah_pkg::S_F_B1L: begin
        cmd.hi_en   = 1'b1;
        cmd.mul_sel = wah_pkg::MUL_B1L;
        state_nxt   = wah_pkg::S_F_B2H;
      end
      wah_pkg::S_F_B2H: begin
        cmd.acc_sub = 1'b1;
        cmd.mul_sel = wah_pkg::MUL_B2H;
        state_nxt   = wah_pkg::S_F_B2L;
      end
      wah_pkg::S_F_B2L: begin
        cmd.hi_en   = 1'b1;
        cmd.mul_sel = wah_pkg::MUL_B2L;
        state_nxt   = wah_pkg::S_F_Y;
      end
      wah_pkg::S_F_Y: begin
        cmd.y_en  = 1'b1;
        state_nxt = wah_pkg::S_F_GH;
      end
      wah_pkg::S_F_GH: begin
        cmd.mul_sel = wah_pkg::MUL_GH;
        state_nxt   = wah_pkg::S_F_GL;
      end
      wah_pkg::S_F_GL: begin
        cmd.hi_en   = 1'b1;
        cmd.mul_sel = wah_pkg::MUL_GL;
        state_nxt   = wah_pkg::S_F_OUT;
      end
      wah_pkg::S_F_OUT: begin
        // hold the gain product steady while the output register is full
        cmd.mul_sel = wah_pkg::MUL_GL;
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = wah_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wah_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != wah_pkg::S_IDLE))
    else $error("accepted transaction did not start work");

  a_out_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (state_r == wah_pkg::S_F_OUT) && !status.out_busy)
    else $error("output loaded outside the output step");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wah_pkg::S_DIV && status.div_done) |=> (state_r == wah_pkg::S_L_R))
    else $error("divider finish not followed by radius step");

  a_coef_before_filter: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gain_en |=> (state_r == wah_pkg::S_F_B1H))
    else $error("gain update not followed by filtering");

endmodule

>>> sv/wah_resonant_two_pole_filter.sv
// ----------------------------------------------------------------------------
// wah_resonant_two_pole_filter
// Resonant two-pole filter, the core of a wah-wah effect.
// ----------------------------------------------------------------------------
// One sample per transaction. A plain sample passes six times through the
// single shared 33x33 multiplier, plus accumulate and saturate steps, before
// its result is loaded; a full output register that is stalled holds the load
// back. A transaction with block_start set first recomputes the coefficients,
// including a pass through the one-bit-per-cycle divider that forms (theta << 8)
// over Q. The next transaction is accepted in the cycle after the result is
// loaded into the output register, even while that result waits to be taken.
// ----------------------------------------------------------------------------
module wah_resonant_two_pole_filter #(
  parameter int SAMPLE_WIDTH = wah_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = wah_pkg::ACC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic [15:0]                    in_center_freq,
  input  logic [15:0]                    in_quality,
  input  logic                           in_block_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out
);

  wah_pkg::cmd_t    cmd;
  wah_pkg::status_t status;

  wah_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_block_start (in_block_start),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .status         (status)
  );

  wah_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .in_center_freq (in_center_freq),
    .in_quality     (in_quality),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

>>> test/wah_resonant_two_pole_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wah_resonant_two_pole_filter_test
// Self-checking bench for the resonant two-pole filter: drives samples and
// block starts with random gaps and stalls, predicts each filtered sample in
// fixed point and compares it with the block's output in order.
// ----------------------------------------------------------------------------
class wah_scoreboard;
  logic [31:0]         freq_scale;
  logic signed [63:0]  y1, y2;
  logic signed [31:0]  b1, b2, gain;
  logic signed [23:0]  pending[$];
  int                  errors;

  function new();
    freq_scale = wah_pkg::FREQ_SCALE_RST;
    y1 = 0; y2 = 0; b1 = 0; b2 = 0; gain = 0;
    errors = 0;
  endfunction

  function logic signed [63:0] scaled_product(logic signed [31:0] b, logic signed [63:0] y);
    logic signed [63:0] yh, yl, ph, pl;
    yh = y >>> 16;
    yl = y - (yh <<< 16);
    ph = 64'(b) * yh;
    pl = 64'(b) * yl;
    return (ph + (pl >>> 16)) >>> 13;
  endfunction

  function void latch_coefficients(logic [15:0] freq, logic [15:0] q);
    logic [63:0] prod, theta, sinv, r, omr, t, quot;
    logic signed [63:0] cosv, rc;
    prod = 64'(freq) * 64'(freq_scale);
    if (prod > (64'd2 << 32)) prod = 64'd2 << 32;
    theta = prod >> 2;
    cosv = (64'sd1 <<< 30) - $signed((theta * theta) >> 31);
    sinv = (theta > (64'd1 << 30)) ? (64'd1 << 30) : theta;
    if (q == 0) r = 0;
    else begin
      quot = (theta << 8) / 64'(q);
      r = (quot >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - quot;
    end
    rc = $signed(r) * cosv;
    b1 = 32'(-(rc >>> 30));
    b2 = 32'((r * r) >> 31);
    omr = (64'd1 << 30) - r;
    t = omr + ((r * sinv) >> 30);
    gain = 32'((omr * t) >> 31);
  endfunction

  function void note_input(logic signed [23:0] x, logic [15:0] freq, logic [15:0] q,
                           logic start);
    logic signed [63:0] acc, y, o;
    if (start) latch_coefficients(freq, q);
    acc = (64'(x) <<< 8) - scaled_product(b1, y1) - scaled_product(b2, y2);
    y = acc;
    if (acc > ((64'sd1 <<< 39) - 1)) y = (64'sd1 <<< 39) - 1;
    if (acc < -(64'sd1 <<< 39)) y = -(64'sd1 <<< 39);
    y2 = y1;
    y1 = y;
    o = scaled_product(gain, y) >>> 8;
    if (o > 64'sd8388607) o = 64'sd8388607;
    if (o < -64'sd8388608) o = -64'sd8388608;
    pending.push_back(24'(o));
  endfunction

  function void check_output(logic signed [23:0] got);
    logic signed [23:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected output %0d", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want !== got) begin
      $display("%0t: sample_out expected %0d actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module wah_resonant_two_pole_filter_test;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic signed [23:0] in_sample_in = 0;
  logic [15:0] in_center_freq = 0;
  logic [15:0] in_quality = 0;
  logic        in_block_start = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic signed [23:0] out_sample_out;
  bit          stall_enable = 1;

  wah_scoreboard sb = new();

  wah_resonant_two_pole_filter dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_in(in_sample_in),
    .in_center_freq(in_center_freq), .in_quality(in_quality),
    .in_block_start(in_block_start), .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out)
  );

  always #4 clk = ~clk;

  function int gap_length();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_sample(logic [23:0] x, logic [15:0] f, logic [15:0] q, logic s,
                             bit gaps);
    if (gaps) idle_cycles(gap_length());
    in_valid = 1;
    in_sample_in = x;
    in_center_freq = f;
    in_quality = q;
    in_block_start = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(x, f, q, s);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    idle_cycles(80);
  endtask

  task automatic write_scale(logic [31:0] v);
    drain();
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    sb.freq_scale = v;
  endtask

  task automatic random_block(int n, bit gaps);
    logic [15:0] f, q;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: f = 16'($urandom_range(0, 65535));
        default: f = 16'($urandom_range(0, 5000));
      endcase
      case ($urandom_range(0, 4))
        0: q = 16'($urandom_range(0, 65535));
        1: q = 16'd0;
        default: q = 16'($urandom_range(256, 8192));
      endcase
      send_sample(24'($urandom), f, q, ($urandom_range(0, 15) == 0), gaps);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_output(out_sample_out);
  end

  always @(negedge clk) begin
    if (!stall_enable) out_stall <= 0;
    else if ($urandom_range(0, 29) == 0) out_stall <= 1;
    else if (out_stall && $urandom_range(0, 3) != 0) out_stall <= out_stall;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    send_sample(24'h7FFFFF, 0, 0, 0, 0);
    send_sample(24'h800000, 0, 0, 0, 0);
    send_sample(24'h7FFFFF, 1000, 512, 1, 1);
    send_sample(24'h800000, 0, 0, 0, 1);
    send_sample(24'h7FFFFF, 1000, 0, 1, 0);
    send_sample(24'h123456, 65535, 65535, 1, 0);
    send_sample(24'h800000, 65535, 65535, 0, 0);
    send_sample(24'h400000, 100, 1, 1, 0);
    send_sample(24'h000000, 200, 65535, 1, 0);
    send_sample(24'hFFFFFF, 0, 65535, 1, 0);
    send_sample(24'h7FFFFF, 50, 65535, 1, 0);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 24'h800000 : 24'h7FFFFF, 0, 0, 0, 0);
    write_scale(32'hFFFFFFFF);
    send_sample(24'h200000, 1, 512, 1, 1);
    write_scale(32'h0);
    send_sample(24'h200000, 65535, 512, 1, 1);
    write_scale(wah_pkg::FREQ_SCALE_RST);
    random_block(400, 1);
    drain();
    stall_enable = 0;
    random_block(150, 0);
    stall_enable = 1;
    write_scale($urandom);
    random_block(200, 1);
    write_scale($urandom_range(1000, 100000));
    random_block(300, 1);
    write_scale(32'h0000_0001);
    random_block(100, 1);
    write_scale(wah_pkg::FREQ_SCALE_RST);
    random_block(100, 1);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> filelist.f
sv/wah_pkg.sv
sv/wah_dp.sv
sv/wah_ctrl.sv
sv/wah_resonant_two_pole_filter.sv
test/wah_resonant_two_pole_filter_test.sv
